FILE: rtl/core/wsd_pkg.sv
// Shared request codes and controller command bundle for the task deque.
// No dependencies; used by wsd_ctrl, wsd_datapath and work_stealing_deque.
package wsd_pkg;

  typedef enum logic [1:0] {
    REQ_PUSH_BOTTOM = 2'd0,
    REQ_POP_TOP     = 2'd1,
    REQ_POP_BOTTOM  = 2'd2,
    REQ_NONE        = 2'd3
  } req_type_t;

  localparam logic [3:0] INIT_LOG_RESET = 4'd4;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;     // capture the request fields
    logic exec;     // update indices, access the store, register flags
    logic respond;  // result registers are on the ports this cycle
  } ctl_cmd_t;

endpackage

FILE: rtl/core/wsd_ctrl.sv
// Request sequencer for the task deque: idle, execute, respond.
// Depends on wsd_pkg for the command bundle.
module wsd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output wsd_pkg::ctl_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_RESP = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (start) state_next = ST_EXEC;
      ST_EXEC: state_next = ST_RESP;
      ST_RESP: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy        = (state != ST_IDLE);
  assign cmd.load    = (state == ST_IDLE) && start;
  assign cmd.exec    = (state == ST_EXEC);
  assign cmd.respond = (state == ST_RESP);

endmodule

FILE: rtl/core/wsd_datapath.sv
// Deque datapath: task store, top/bottom indices, capacity and its configuration load.
// Depends on wsd_pkg for request codes and the command bundle.
module wsd_datapath #(
  parameter int MAX_LOG_CAPACITY = 10,
  parameter int TASK_WIDTH       = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  wsd_pkg::ctl_cmd_t cmd,
  input  logic [1:0]        req_type,
  input  logic [31:0]       task_id,
  input  logic              cfg_write,
  input  logic [3:0]        cfg_data,
  output logic [31:0]       out_task_id,
  output logic              task_valid,
  output logic              push_rejected,
  output logic [9:0]        item_count,
  output logic [3:0]        current_log_capacity
);

  localparam int AW = MAX_LOG_CAPACITY;
  localparam int IW = MAX_LOG_CAPACITY + 1;
  localparam int LW = $clog2(MAX_LOG_CAPACITY + 1);
  localparam int DEPTH = 1 << MAX_LOG_CAPACITY;

  function automatic logic [LW-1:0] clamp_log(input logic [3:0] v);
    if (v == 4'd0) begin
      return LW'(1);
    end else if (32'(v) > MAX_LOG_CAPACITY) begin
      return LW'(MAX_LOG_CAPACITY);
    end else begin
      return LW'(v);
    end
  endfunction

  logic [TASK_WIDTH-1:0] task_store [DEPTH];

  logic [1:0]            req_q;
  logic [TASK_WIDTH-1:0] task_q;
  logic [IW-1:0]         top_index;
  logic [IW-1:0]         bottom_index;
  logic [LW-1:0]         log_now;
  logic [TASK_WIDTH-1:0] rd_data;
  logic                  valid_q;
  logic                  rejected_q;

  logic [IW-1:0] count;
  logic [IW-1:0] cap_m1;
  logic [IW-1:0] last_index;
  logic [IW-1:0] top_next;
  logic [IW-1:0] bottom_next;
  logic [LW-1:0] log_next;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic          valid_next;
  logic          rejected_next;

  assign count      = bottom_index - top_index;
  assign cap_m1     = (IW'(1) << log_now) - IW'(1);
  assign last_index = bottom_index - IW'(1);

  always_comb begin
    top_next      = top_index;
    bottom_next   = bottom_index;
    log_next      = log_now;
    rd_addr       = top_index[AW-1:0];
    wr_en         = 1'b0;
    valid_next    = 1'b0;
    rejected_next = 1'b0;
    unique case (wsd_pkg::req_type_t'(req_q))
      wsd_pkg::REQ_PUSH_BOTTOM: begin
        if (count >= cap_m1 && 32'(log_now) >= MAX_LOG_CAPACITY) begin
          rejected_next = 1'b1;
        end else begin
          if (count >= cap_m1) log_next = log_now + LW'(1);
          wr_en       = 1'b1;
          bottom_next = bottom_index + IW'(1);
        end
      end
      wsd_pkg::REQ_POP_TOP: begin
        if (count != '0) begin
          valid_next = 1'b1;
          top_next   = top_index + IW'(1);
        end
      end
      wsd_pkg::REQ_POP_BOTTOM: begin
        rd_addr = last_index[AW-1:0];
        if (count != '0) begin
          valid_next = 1'b1;
          // Taking the last task empties the deque by advancing top instead
          if (count == IW'(1)) top_next = top_index + IW'(1);
          else bottom_next = last_index;
        end
      end
      wsd_pkg::REQ_NONE: begin
      end
      default: begin
      end
    endcase
  end

  // Store: one write (push only) and one registered read per request
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (wr_en) task_store[bottom_index[AW-1:0]] <= task_q;
      rd_data <= task_store[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q  <= req_type;
      task_q <= TASK_WIDTH'(task_id);
    end
    if (cmd.exec) begin
      valid_q    <= valid_next;
      rejected_q <= rejected_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      top_index    <= '0;
      bottom_index <= '0;
      log_now      <= clamp_log(wsd_pkg::INIT_LOG_RESET);
    end else if (cmd.exec) begin
      top_index    <= top_next;
      bottom_index <= bottom_next;
      log_now      <= log_next;
    end else if (cfg_write) begin
      if (count == '0) log_now <= clamp_log(cfg_data);
    end
  end

  assign out_task_id          = valid_q ? 32'(rd_data) : 32'd0;
  assign task_valid           = valid_q;
  assign push_rejected        = rejected_q;
  assign item_count           = 10'(count);
  assign current_log_capacity = 4'(log_now);

endmodule

FILE: rtl/core/work_stealing_deque.sv
// Top level of the work-stealing task deque: controller plus datapath.
// Depends on wsd_pkg, wsd_ctrl and wsd_datapath.
// A request is accepted in the idle state, then passes through execute and
// respond; done is high in respond and the result is taken at its end.
// A new request is accepted only in the idle state; the store has one write
// and one registered read, sequenced through accept, execute and respond.
// The receiver cannot stall: each result stands for exactly one cycle.
// Reset (rst, synchronous): indices cleared, capacity register back to 4.
module work_stealing_deque #(
  parameter int MAX_LOG_CAPACITY = 10,
  parameter int TASK_WIDTH       = 32
) (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type,
  input  logic [31:0] task_id,
  // configuration: initial_log_capacity
  input  logic        cfg_write,
  input  logic [3:0]  cfg_data,
  // result channel, done strobes once per result
  output logic        done,
  output logic [31:0] out_task_id,
  output logic        task_valid,
  output logic        push_rejected,
  output logic [9:0]  item_count,
  output logic [3:0]  current_log_capacity
);

  wsd_pkg::ctl_cmd_t cmd;

  // Sequence each request: capture, execute against the store, present
  wsd_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // Hold the task store, the free-running top and bottom indices and the
  // logical capacity; the capacity doubles on a push near full, and a push near
  // full at the maximum capacity is dropped and flagged.
  wsd_datapath #(
    .MAX_LOG_CAPACITY (MAX_LOG_CAPACITY),
    .TASK_WIDTH       (TASK_WIDTH)
  ) u_datapath (
    .clk                  (clk),
    .rst                  (rst),
    .cmd                  (cmd),
    .req_type             (req_type),
    .task_id              (task_id),
    .cfg_write            (cfg_write),
    .cfg_data             (cfg_data),
    .out_task_id          (out_task_id),
    .task_valid           (task_valid),
    .push_rejected        (push_rejected),
    .item_count           (item_count),
    .current_log_capacity (current_log_capacity)
  );

  // Raise the strobe for the single respond cycle of each request
  assign done = cmd.respond;

endmodule

FILE: tb/sv/work_stealing_deque_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the work-stealing task deque (work_stealing_deque).
// Depends on wsd_pkg and the RTL under rtl/core; a scoreboard class predicts every result.
module work_stealing_deque_tb;

  localparam int MAX_LOG     = 10;
  localparam int STALL_LIMIT = 2000;  // cycles with no request or result accepted
  localparam int PRINT_LIMIT = 100;   // stop printing mismatches past this, keep counting

  // One result as it appears on the result ports
  typedef struct packed {
    logic [31:0] id;
    logic        valid;
    logic        rejected;
    logic [9:0]  held;
    logic [3:0]  log_cap;
  } deque_result_t;

  // Shadow deque: own copy of the indices, the store and the capacity register,
  // plus the queue of results still owed by the block.
  class deque_scoreboard;
    logic [31:0]   task_slots [1 << MAX_LOG];
    logic [10:0]   top_idx;
    logic [10:0]   bot_idx;
    logic [3:0]    log_cap_now;
    logic [3:0]    init_cap_reg;
    deque_result_t expected_results [$];
    int            errors;
    int            results_seen;
    int            rejected_pushes;

    function new();
      top_idx         = '0;
      bot_idx         = '0;
      init_cap_reg    = wsd_pkg::INIT_LOG_RESET;
      log_cap_now     = clamp_cap(wsd_pkg::INIT_LOG_RESET);
      errors          = 0;
      results_seen    = 0;
      rejected_pushes = 0;
    endfunction

    function logic [3:0] clamp_cap(logic [3:0] v);
      if (v < 4'd1) return 4'd1;
      if (v > 4'(MAX_LOG)) return 4'(MAX_LOG);
      return v;
    endfunction

    function logic [10:0] held_now();
      return bot_idx - top_idx;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // The register always takes the value; the live capacity follows only when empty
    function void load_init_cap(logic [3:0] v);
      init_cap_reg = v;
      if (held_now() == '0) log_cap_now = clamp_cap(v);
    endfunction

    // Work out the result of one accepted request and queue it
    function void note_request(wsd_pkg::req_type_t req, logic [31:0] id);
      deque_result_t want;
      int unsigned   held;
      int unsigned   cap_size;
      logic [10:0]   last;
      want = '0;
      held = 32'(held_now());
      case (req)
        wsd_pkg::REQ_PUSH_BOTTOM: begin
          cap_size = 1 << log_cap_now;
          if (held >= cap_size - 1 && log_cap_now == 4'(MAX_LOG)) begin
            want.rejected = 1'b1;
            rejected_pushes++;
          end else begin
            if (held >= cap_size - 1) log_cap_now++;
            task_slots[bot_idx[MAX_LOG-1:0]] = id;
            bot_idx++;
          end
        end
        wsd_pkg::REQ_POP_TOP: begin
          if (held != 0) begin
            want.id    = task_slots[top_idx[MAX_LOG-1:0]];
            want.valid = 1'b1;
            top_idx++;
          end
        end
        wsd_pkg::REQ_POP_BOTTOM: begin
          if (held != 0) begin
            last       = bot_idx - 11'd1;
            want.id    = task_slots[last[MAX_LOG-1:0]];
            want.valid = 1'b1;
            if (held == 1) top_idx++;
            else bot_idx = last;
          end
        end
        default: ;
      endcase
      want.held    = 10'(held_now());
      want.log_cap = log_cap_now;
      expected_results.push_back(want);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      if (errors <= PRINT_LIMIT)
        $display("[%0t] result %0d: %s got %0h expected %0h",
                 $realtime, results_seen, what, got, want);
    endtask

    // Compare one result with the oldest expectation, field by field
    task check_result(deque_result_t got);
      deque_result_t want;
      results_seen++;
      if (expected_results.size() == 0) begin
        report("result with no request outstanding", got.id, '0);
        return;
      end
      want = expected_results.pop_front();
      if (got.id !== want.id) report("out_task_id", got.id, want.id);
      if (got.valid !== want.valid)
        report("task_valid", 32'(got.valid), 32'(want.valid));
      if (got.rejected !== want.rejected)
        report("push_rejected", 32'(got.rejected), 32'(want.rejected));
      if (got.held !== want.held) report("item_count", 32'(got.held), 32'(want.held));
      if (got.log_cap !== want.log_cap)
        report("current_log_capacity", 32'(got.log_cap), 32'(want.log_cap));
    endtask

    task flag_leftovers();
      while (expected_results.size() != 0) begin
        report("result never arrived", '0, expected_results[0].id);
        void'(expected_results.pop_front());
      end
    endtask
  endclass

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  wsd_pkg::req_type_t req_type;
  logic [31:0]        task_id;
  logic               cfg_write;
  logic [3:0]         cfg_data;
  logic               done;
  logic [31:0]        out_task_id;
  logic               task_valid;
  logic               push_rejected;
  logic [9:0]         item_count;
  logic [3:0]         current_log_capacity;

  deque_scoreboard sb;
  int              quiet_cycles;

  work_stealing_deque DUT (
    .clk                 (clk),
    .rst                 (rst),
    .start               (start),
    .busy                (busy),
    .req_type            (req_type),
    .task_id             (task_id),
    .cfg_write           (cfg_write),
    .cfg_data            (cfg_data),
    .done                (done),
    .out_task_id         (out_task_id),
    .task_valid          (task_valid),
    .push_rejected       (push_rejected),
    .item_count          (item_count),
    .current_log_capacity(current_log_capacity)
  );

  // 20 ns period, first rising edge at 10 ns
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Observe at the rising edge: inputs were set on the falling edge, so every
  // sampled value is the one the block itself sees at this edge.
  always @(posedge clk) begin
    if (!rst) begin
      // A configuration write lands at this edge; the block is idle by construction
      if (cfg_write) sb.load_init_cap(cfg_data);
      // Note the request before checking: a result always belongs to an older request
      if (start && !busy) sb.note_request(req_type, task_id);
      if (done)
        sb.check_result('{out_task_id, task_valid, push_rejected, item_count,
                          current_log_capacity});
      // Watchdog: give up when nothing moves for too long
      if ((start && !busy) || done) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no request or result accepted for %0d cycles", STALL_LIMIT);
        $display("work_stealing_deque_tb failed");
        $finish;
      end
    end
  end

  // Present one request from the next falling edge and hold it until accepted
  task automatic issue(wsd_pkg::req_type_t req, logic [31:0] id);
    @(negedge clk);
    start    <= 1'b1;
    req_type <= req;
    task_id  <= id;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Idle the request side for a random run of cycles; pct is the chance per cycle
  task automatic hold_off(int pct);
    while ($urandom_range(99) < pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // Drop start and wait until every outstanding request has produced its result
  task automatic drain_pending();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending() != 0 || busy) @(negedge clk);
  endtask

  task automatic write_init_cap(logic [3:0] v);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Weighted request mix: pushes at push_pct, a little unused-type noise,
  // the rest split between steals and bottom pops
  function automatic wsd_pkg::req_type_t pick_request(int push_pct);
    int roll;
    roll = $urandom_range(99);
    if (roll < push_pct) return wsd_pkg::REQ_PUSH_BOTTOM;
    if (roll >= 96) return wsd_pkg::REQ_NONE;
    if (roll < push_pct + (96 - push_pct) / 2) return wsd_pkg::REQ_POP_TOP;
    return wsd_pkg::REQ_POP_BOTTOM;
  endfunction

  task automatic run_mixed(int n, int push_pct, int idle_pct);
    for (int i = 0; i < n; i++) begin
      issue(pick_request(push_pct), $urandom);
      hold_off(idle_pct);
      // Now and then let the block run dry before the next request
      if ($urandom_range(59) == 0) drain_pending();
    end
  endtask

  initial begin
    int guard;
    sb           = new();
    quiet_cycles = 0;
    rst          = 1'b1;
    start        = 1'b0;
    req_type     = wsd_pkg::REQ_NONE;
    task_id      = '0;
    cfg_write    = 1'b0;
    cfg_data     = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Out-of-range low value: capacity clamps up to 2 entries
    write_init_cap(4'd0);

    // Directed: empty pops, unused type, last-task pop from the bottom, growth
    issue(wsd_pkg::REQ_NONE, 32'hDEAD_BEEF);
    issue(wsd_pkg::REQ_POP_TOP, '0);
    issue(wsd_pkg::REQ_POP_BOTTOM, '0);
    issue(wsd_pkg::REQ_PUSH_BOTTOM, 32'h0000_0000);
    issue(wsd_pkg::REQ_POP_BOTTOM, '0);
    issue(wsd_pkg::REQ_PUSH_BOTTOM, 32'hFFFF_FFFF);
    issue(wsd_pkg::REQ_PUSH_BOTTOM, 32'hAAAA_AAAA);
    issue(wsd_pkg::REQ_PUSH_BOTTOM, 32'h5555_5555);
    issue(wsd_pkg::REQ_PUSH_BOTTOM, 32'h0000_0001);
    issue(wsd_pkg::REQ_PUSH_BOTTOM, 32'h8000_0000);
    issue(wsd_pkg::REQ_NONE, 32'h1234_5678);

    // Write while holding tasks: register takes 15, live capacity must not move
    drain_pending();
    write_init_cap(4'd15);

    issue(wsd_pkg::REQ_POP_TOP, '0);
    issue(wsd_pkg::REQ_POP_BOTTOM, '0);
    issue(wsd_pkg::REQ_POP_TOP, '0);
    issue(wsd_pkg::REQ_POP_BOTTOM, '0);
    issue(wsd_pkg::REQ_POP_TOP, '0);
    issue(wsd_pkg::REQ_POP_BOTTOM, '0);
    issue(wsd_pkg::REQ_PUSH_BOTTOM, 32'h7FFF_FFFF);
    issue(wsd_pkg::REQ_POP_TOP, '0);
    issue(wsd_pkg::REQ_POP_TOP, '0);

    // Empty again: start at the full capacity, no idling
    drain_pending();
    write_init_cap(4'd10);
    run_mixed(30, 55, 0);

    // Smallest capacity, request side idle most of the time
    drain_pending();
    write_init_cap(4'd1);
    run_mixed(30, 55, 80);

    // Random start, then fill until pushes bounce off the maximum
    drain_pending();
    write_init_cap(4'($urandom_range(15)));
    guard = 0;
    while (sb.rejected_pushes < 15 && guard < 3000) begin
      issue(pick_request(96), $urandom);
      hold_off(13);
      guard++;
    end

    // Write while full, then drain mostly by pops
    drain_pending();
    write_init_cap(4'($urandom_range(15)));
    run_mixed(30, 20, 13);

    // Settle: everything owed, then a few extra cycles to catch stray results
    drain_pending();
    repeat (6) @(posedge clk);
    sb.flag_leftovers();
    if (sb.errors == 0)
      $display("work_stealing_deque_tb passed");
    else
      $display("work_stealing_deque_tb failed");
    $finish;
  end

endmodule
